>>> hw/rtl/mlp_pkg.sv
// shared constants and arithmetic helpers for the lookahead planner
package mlp_pkg;

	localparam int RING_DEPTH_DEF = 16;
	localparam int AXIS_COUNT_DEF = 4;
	localparam int MAX_AXES       = 4;
	localparam int SPEED_W        = 32;
	localparam int STEP_W         = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [SPEED_W-1:0] speed_t;

	// saturating add of two squared speeds
	function automatic speed_t sat_add(input speed_t a, input speed_t b);
		logic [SPEED_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SPEED_W] ? '1 : s[SPEED_W-1:0];
	endfunction

	function automatic speed_t min_speed(input speed_t a, input speed_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

>>> hw/rtl/mlp_ram.sv
// generic single write, single read ram with registered read data
module mlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/motion_lookahead_planner_core.sv
// lookahead junction speed planner: ring of motion blocks with replanning
//
// usage: one input channel (in_valid/in_ready) carries transactions that
// either push a move (operation = push) or discard the tail move (pop).
// every transaction gives exactly one result on the output channel
// (out_valid/out_ready) that describes the tail move after the operation.
// the block works on one transaction at a time; in_ready is high only
// while the sequencer is idle.
// a pop or a rejected push goes from acceptance straight to the result
// phase. an accepted push writes the new move, then the reverse pass and
// the forward pass read and then update each visited move in separate
// states, set by the single read port of the block memories.
// reset clears the state, the pointers and out_valid only; memory contents
// stay undefined and are never used before they are written.
// if the receiver stalls, the result is held in the output registers and
// the next transaction is still accepted; it waits before its result phase
// until the held result has been taken.
module motion_lookahead_planner_core import mlp_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [31:0] step_axis0,
	input  logic signed [31:0] step_axis1,
	input  logic signed [31:0] step_axis2,
	input  logic signed [31:0] step_axis3,
	input  logic        [31:0] speed_change_limit,
	input  logic        [31:0] cruise_speed_sq,
	input  logic        [31:0] junction_limit_sq,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               push_rejected,
	output logic               ring_full,
	output logic               ring_empty,
	output logic signed [31:0] cur_step_axis0,
	output logic signed [31:0] cur_step_axis1,
	output logic signed [31:0] cur_step_axis2,
	output logic signed [31:0] cur_step_axis3,
	output logic        [31:0] cur_entry_sq,
	output logic        [31:0] cur_cruise_sq,
	output logic        [31:0] cur_exit_sq
);

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int STEPS_W = AXIS_COUNT * STEP_W;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_WR,
		ST_REV_RD,
		ST_REV_UPD,
		ST_FWD_RD0,
		ST_FWD_CAP,
		ST_FWD_RD,
		ST_FWD_UPD,
		ST_OUT_RD,
		ST_OUT_EX,
		ST_OUT_FIN
	} state_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST_SLOT : p - 1'b1;
	endfunction

	state_t            state_q;
	logic [PTR_W-1:0]  tail_q, head_q, planned_q, idx_q;
	logic              rejected_q;
	logic [STEPS_W-1:0] steps_in_q;
	speed_t            chg_in_q, cru_in_q, jun_in_q, last_cru_q;
	speed_t            e_carry_q, ch_carry_q;
	logic [STEPS_W-1:0] cur_steps_q;

	// memory ports
	logic [PTR_W-1:0]   rd_addr;
	logic               push_wr, ent_wr;
	logic [PTR_W-1:0]   ent_waddr;
	speed_t             ent_wdata;
	speed_t             ent_rd, cru_rd, chg_rd, lim_rd;
	logic [STEPS_W-1:0] steps_rd;
	logic [STEPS_W-1:0] steps_in;
	logic signed [31:0] in_steps [MAX_AXES];

	// combinational step results
	speed_t lim_new, head_entry, rev_new, fwd_sum, fwd_new;
	logic   fwd_lower;
	logic   is_empty;

	assign in_steps[0] = step_axis0;
	assign in_steps[1] = step_axis1;
	assign in_steps[2] = step_axis2;
	assign in_steps[3] = step_axis3;

	for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_pack
		assign steps_in[a*STEP_W +: STEP_W] = in_steps[a];
	end

	// entry limit of a pushed move: zero for the first move in the ring
	assign lim_new = (head_q == tail_q) ? '0 :
		min_speed(min_speed(jun_in_q, cru_in_q), last_cru_q);
	// newest move starts at its own stop limit unless it is already planned
	assign head_entry = (head_q == planned_q) ? '0 : min_speed(lim_new, chg_in_q);

	// reverse pass: entry = min(next entry + change, limit) unless at limit
	assign rev_new = (ent_rd != lim_rd) ?
		min_speed(sat_add(e_carry_q, chg_rd), lim_rd) : ent_rd;

	// forward pass: cap next entry by what acceleration from this one allows
	assign fwd_sum   = sat_add(e_carry_q, ch_carry_q);
	assign fwd_lower = (e_carry_q < ent_rd) && (fwd_sum < ent_rd);
	assign fwd_new   = fwd_lower ? fwd_sum : ent_rd;

	assign is_empty = (head_q == tail_q);

	always_comb begin
		rd_addr   = idx_q;
		push_wr   = 1'b0;
		ent_wr    = 1'b0;
		ent_waddr = idx_q;
		ent_wdata = rev_new;
		unique case (state_q)
			ST_PUSH_WR: begin
				push_wr   = 1'b1;
				ent_wr    = 1'b1;
				ent_waddr = head_q;
				ent_wdata = head_entry;
			end
			ST_REV_UPD: begin
				ent_wr    = (ent_rd != lim_rd);
				ent_wdata = rev_new;
			end
			ST_FWD_RD0: rd_addr = planned_q;
			ST_FWD_UPD: begin
				ent_wr    = fwd_lower;
				ent_wdata = fwd_sum;
			end
			ST_OUT_RD:  rd_addr = tail_q;
			ST_OUT_EX:  rd_addr = ptr_next(tail_q);
			default: begin
			end
		endcase
	end

	mlp_ram #(.WIDTH(STEPS_W), .DEPTH(RING_DEPTH)) u_step_ram (
		.clk(clk), .wr_en(push_wr), .wr_addr(head_q), .wr_data(steps_in_q),
		.rd_addr(rd_addr), .rd_data(steps_rd)
	);
	mlp_ram #(.WIDTH(SPEED_W), .DEPTH(RING_DEPTH)) u_entry_ram (
		.clk(clk), .wr_en(ent_wr), .wr_addr(ent_waddr), .wr_data(ent_wdata),
		.rd_addr(rd_addr), .rd_data(ent_rd)
	);
	mlp_ram #(.WIDTH(SPEED_W), .DEPTH(RING_DEPTH)) u_cruise_ram (
		.clk(clk), .wr_en(push_wr), .wr_addr(head_q), .wr_data(cru_in_q),
		.rd_addr(rd_addr), .rd_data(cru_rd)
	);
	mlp_ram #(.WIDTH(SPEED_W), .DEPTH(RING_DEPTH)) u_change_ram (
		.clk(clk), .wr_en(push_wr), .wr_addr(head_q), .wr_data(chg_in_q),
		.rd_addr(rd_addr), .rd_data(chg_rd)
	);
	mlp_ram #(.WIDTH(SPEED_W), .DEPTH(RING_DEPTH)) u_limit_ram (
		.clk(clk), .wr_en(push_wr), .wr_addr(head_q), .wr_data(lim_new),
		.rd_addr(rd_addr), .rd_data(lim_rd)
	);

	assign in_ready = (state_q == ST_IDLE);

	// sequencer with pointers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tail_q        <= '0;
			head_q        <= '0;
			planned_q     <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						steps_in_q <= steps_in;
						chg_in_q   <= speed_change_limit;
						cru_in_q   <= cruise_speed_sq;
						jun_in_q   <= junction_limit_sq;
						rejected_q <= 1'b0;
						if (operation == OP_PUSH) begin
							if (tail_q == ptr_next(head_q)) begin
								rejected_q <= 1'b1;
								state_q    <= ST_OUT_RD;
							end else begin
								state_q <= ST_PUSH_WR;
							end
						end else begin
							if (!is_empty) begin
								if (tail_q == planned_q) begin
									planned_q <= ptr_next(tail_q);
								end
								tail_q <= ptr_next(tail_q);
							end
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_PUSH_WR: begin
					last_cru_q <= cru_in_q;
					head_q     <= ptr_next(head_q);
					e_carry_q  <= head_entry;
					idx_q      <= ptr_prev(head_q);
					priority if (head_q == planned_q) begin
						state_q <= ST_OUT_RD;
					end else if (ptr_prev(head_q) == planned_q) begin
						state_q <= ST_FWD_RD0;
					end else begin
						state_q <= ST_REV_RD;
					end
				end
				ST_REV_RD: state_q <= ST_REV_UPD;
				ST_REV_UPD: begin
					e_carry_q <= rev_new;
					idx_q     <= ptr_prev(idx_q);
					state_q   <= (ptr_prev(idx_q) == planned_q) ? ST_FWD_RD0 : ST_REV_RD;
				end
				ST_FWD_RD0: state_q <= ST_FWD_CAP;
				ST_FWD_CAP: begin
					e_carry_q  <= ent_rd;
					ch_carry_q <= chg_rd;
					idx_q      <= ptr_next(planned_q);
					state_q    <= (ptr_next(planned_q) == head_q) ? ST_OUT_RD : ST_FWD_RD;
				end
				ST_FWD_RD: state_q <= ST_FWD_UPD;
				ST_FWD_UPD: begin
					if (fwd_lower || (fwd_new == lim_rd)) begin
						planned_q <= idx_q;
					end
					e_carry_q  <= fwd_new;
					ch_carry_q <= chg_rd;
					idx_q      <= ptr_next(idx_q);
					state_q    <= (ptr_next(idx_q) == head_q) ? ST_OUT_RD : ST_FWD_RD;
				end
				ST_OUT_RD: begin
					// hold until the previous result has left
					if (!out_valid || out_ready) begin
						state_q <= ST_OUT_EX;
					end
				end
				ST_OUT_EX: begin
					cur_steps_q   <= is_empty ? '0 : steps_rd;
					cur_entry_sq  <= is_empty ? '0 : ent_rd;
					cur_cruise_sq <= is_empty ? '0 : cru_rd;
					state_q       <= ST_OUT_FIN;
				end
				ST_OUT_FIN: begin
					cur_exit_sq   <= (is_empty || ptr_next(tail_q) == head_q) ? '0 : ent_rd;
					push_rejected <= rejected_q;
					ring_full     <= (tail_q == ptr_next(head_q));
					ring_empty    <= is_empty;
					out_valid     <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// unpack tail steps; unused axes read zero
	logic signed [31:0] cur_steps [MAX_AXES];
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_unpack
		if (a < AXIS_COUNT) begin : g_used
			assign cur_steps[a] = cur_steps_q[a*STEP_W +: STEP_W];
		end else begin : g_unused
			assign cur_steps[a] = '0;
		end
	end
	assign cur_step_axis0 = cur_steps[0];
	assign cur_step_axis1 = cur_steps[1];
	assign cur_step_axis2 = cur_steps[2];
	assign cur_step_axis3 = cur_steps[3];

	// reverse pass never reaches the planned move
	a_rev_not_planned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REV_UPD) |-> (idx_q != planned_q))
		else $error("reverse pass touched planned move");

	// forward pass only lowers an entry speed
	a_fwd_lowers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD_UPD && ent_wr) |-> (ent_wdata < ent_rd))
		else $error("forward pass raised an entry speed");

	// a rejected push only happens on a full ring
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && push_rejected |-> ring_full)
		else $error("push rejected on a ring with room");

	// empty ring reports zero speeds
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && ring_empty |-> (cur_entry_sq == '0 && cur_exit_sq == '0))
		else $error("empty ring reported a speed");

	// a new result never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_EX) |-> (!out_valid))
		else $error("result overwritten before it was taken");

endmodule
